@@ src/ira_pkg.sv @@
// Shared types, codes and helpers for the I2C register access master.
`default_nettype none
package ira_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [7:0] TIMEOUT_RESET = 8'd250;
    localparam logic [PADDR_W-1:0] ADDR_ACK_TIMEOUT = 3'd0;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_S1        = 4'd1,
        PH_S2        = 4'd2,
        PH_S3        = 4'd3,
        PH_S4        = 4'd4,
        PH_TX_LOW    = 4'd5,
        PH_TX_HIGH   = 4'd6,
        PH_ACK_LOW   = 4'd7,
        PH_ACK_WAIT  = 4'd8,
        PH_RX_LOW    = 4'd9,
        PH_RX_HIGH   = 4'd10,
        PH_NACK_LOW  = 4'd11,
        PH_NACK_HIGH = 4'd12,
        PH_P1        = 4'd13,
        PH_P2        = 4'd14,
        PH_P3        = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        STEP_ADDR  = 2'd0,
        STEP_REG   = 2'd1,
        STEP_DATA  = 2'd2,
        STEP_SPARE = 2'd3
    } t_step;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drive;
    } t_lines;

    typedef struct packed {
        t_lines     lines;
        logic       busy;
        logic       done;
        logic       ack_error;
        logic [7:0] read_value;
    } t_result;

    function automatic logic [7:0] byte_for_step(
        input t_step      step,
        input logic [6:0] dev,
        input logic [7:0] reg_index,
        input logic [7:0] value,
        input logic       is_read
    );
        logic [7:0] dev_byte;
        logic [7:0] res;
        dev_byte = {dev, 1'b0};
        unique case (step)
            STEP_ADDR: res = dev_byte;
            STEP_REG:  res = reg_index;
            default:   res = is_read ? {dev, 1'b1} : value;
        endcase
        return res;
    endfunction

    function automatic t_lines lines_for_phase(input t_phase phase, input logic msb);
        t_lines l;
        unique case (phase)
            PH_S1:        l = '{scl: 1'b0, sda: 1'b1, drive: 1'b1};
            PH_S2:        l = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
            PH_S3:        l = '{scl: 1'b1, sda: 1'b0, drive: 1'b1};
            PH_S4:        l = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
            PH_TX_LOW:    l = '{scl: 1'b0, sda: msb,  drive: 1'b1};
            PH_TX_HIGH:   l = '{scl: 1'b1, sda: msb,  drive: 1'b1};
            PH_ACK_LOW:   l = '{scl: 1'b0, sda: 1'b1, drive: 1'b0};
            PH_ACK_WAIT:  l = '{scl: 1'b1, sda: 1'b1, drive: 1'b0};
            PH_RX_LOW:    l = '{scl: 1'b0, sda: 1'b1, drive: 1'b0};
            PH_RX_HIGH:   l = '{scl: 1'b1, sda: 1'b1, drive: 1'b0};
            PH_NACK_LOW:  l = '{scl: 1'b0, sda: 1'b1, drive: 1'b1};
            PH_NACK_HIGH: l = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
            PH_P1:        l = '{scl: 1'b0, sda: 1'b0, drive: 1'b1};
            PH_P2:        l = '{scl: 1'b1, sda: 1'b0, drive: 1'b1};
            default:      l = '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

@@ src/ira_core.sv @@
// Transaction sequencer: bus phase state machine and per-tick result.
`default_nettype none
module ira_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic [1:0]       i_cmd,
    input  wire logic [6:0]       i_device_address,
    input  wire logic [7:0]       i_register_address,
    input  wire logic [7:0]       i_write_value,
    input  wire logic             i_sda_sample,
    input  wire logic [7:0]       i_ack_timeout_ticks,
    output ira_pkg::t_result      o_result
);

    ira_pkg::t_phase r_phase, n_phase;
    ira_pkg::t_step  r_step, n_step;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_tx_shift, n_tx_shift;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [7:0] r_wait_count, n_wait_count;
    logic [6:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_val, n_val;
    logic       r_is_read, n_is_read;
    logic       r_error, n_error;
    logic       n_done;
    logic [3:0] bit_inc;

    assign bit_inc = r_bit_count + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ira_pkg::PH_IDLE;
            r_step       <= ira_pkg::STEP_ADDR;
            r_bit_count  <= '0;
            r_tx_shift   <= '0;
            r_rx_shift   <= '0;
            r_wait_count <= '0;
            r_is_read    <= 1'b0;
            r_error      <= 1'b0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_step       <= n_step;
            r_bit_count  <= n_bit_count;
            r_tx_shift   <= n_tx_shift;
            r_rx_shift   <= n_rx_shift;
            r_wait_count <= n_wait_count;
            r_is_read    <= n_is_read;
            r_error      <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= '0;
            r_reg <= '0;
            r_val <= '0;
        end else if (i_advance) begin
            r_dev <= n_dev;
            r_reg <= n_reg;
            r_val <= n_val;
        end
    end

    always_comb begin
        logic start_byte;
        start_byte   = 1'b0;
        n_phase      = r_phase;
        n_step       = r_step;
        n_bit_count  = r_bit_count;
        n_tx_shift   = r_tx_shift;
        n_rx_shift   = r_rx_shift;
        n_wait_count = r_wait_count;
        n_dev        = r_dev;
        n_reg        = r_reg;
        n_val        = r_val;
        n_is_read    = r_is_read;
        n_error      = r_error;
        n_done       = 1'b0;
        unique case (r_phase)
            ira_pkg::PH_IDLE: begin
                if (i_cmd == ira_pkg::CMD_WRITE || i_cmd == ira_pkg::CMD_READ) begin
                    n_dev        = i_device_address;
                    n_reg        = i_register_address;
                    n_val        = i_write_value;
                    n_is_read    = (i_cmd == ira_pkg::CMD_READ);
                    if (n_is_read) begin
                        n_rx_shift = '0;
                    end
                    n_error      = 1'b0;
                    n_step       = ira_pkg::STEP_ADDR;
                    n_bit_count  = '0;
                    n_wait_count = '0;
                    n_phase      = ira_pkg::PH_S1;
                end
            end
            ira_pkg::PH_S1: n_phase = ira_pkg::PH_S2;
            ira_pkg::PH_S2: n_phase = ira_pkg::PH_S3;
            ira_pkg::PH_S3: n_phase = ira_pkg::PH_S4;
            ira_pkg::PH_S4: start_byte = 1'b1;
            ira_pkg::PH_TX_LOW: n_phase = ira_pkg::PH_TX_HIGH;
            ira_pkg::PH_TX_HIGH: begin
                n_tx_shift  = {r_tx_shift[6:0], 1'b0};
                n_bit_count = bit_inc;
                if (bit_inc >= 4'd8) begin
                    n_wait_count = '0;
                    n_phase      = ira_pkg::PH_ACK_LOW;
                end else begin
                    n_phase = ira_pkg::PH_TX_LOW;
                end
            end
            ira_pkg::PH_ACK_LOW: n_phase = ira_pkg::PH_ACK_WAIT;
            ira_pkg::PH_ACK_WAIT: begin
                if (!i_sda_sample) begin
                    unique case (r_step)
                        ira_pkg::STEP_ADDR: begin
                            n_step     = ira_pkg::STEP_REG;
                            start_byte = 1'b1;
                        end
                        ira_pkg::STEP_REG: begin
                            n_step = ira_pkg::STEP_DATA;
                            if (r_is_read) begin
                                n_phase = ira_pkg::PH_S1;
                            end else begin
                                start_byte = 1'b1;
                            end
                        end
                        default: begin
                            if (r_is_read) begin
                                n_bit_count = '0;
                                n_phase     = ira_pkg::PH_RX_LOW;
                            end else begin
                                n_phase = ira_pkg::PH_P1;
                            end
                        end
                    endcase
                end else if (r_wait_count >= i_ack_timeout_ticks) begin
                    n_error = 1'b1;
                    n_phase = ira_pkg::PH_P1;
                end else begin
                    n_wait_count = r_wait_count + 8'd1;
                end
            end
            ira_pkg::PH_RX_LOW: n_phase = ira_pkg::PH_RX_HIGH;
            ira_pkg::PH_RX_HIGH: begin
                n_rx_shift  = {r_rx_shift[6:0], i_sda_sample};
                n_bit_count = bit_inc;
                n_phase     = (bit_inc >= 4'd8) ? ira_pkg::PH_NACK_LOW : ira_pkg::PH_RX_LOW;
            end
            ira_pkg::PH_NACK_LOW:  n_phase = ira_pkg::PH_NACK_HIGH;
            ira_pkg::PH_NACK_HIGH: n_phase = ira_pkg::PH_P1;
            ira_pkg::PH_P1:        n_phase = ira_pkg::PH_P2;
            ira_pkg::PH_P2:        n_phase = ira_pkg::PH_P3;
            ira_pkg::PH_P3: begin
                n_phase = ira_pkg::PH_IDLE;
                n_done  = 1'b1;
            end
            default: n_phase = ira_pkg::PH_IDLE;
        endcase
        if (start_byte) begin
            n_tx_shift  = ira_pkg::byte_for_step(n_step, n_dev, n_reg, n_val, n_is_read);
            n_bit_count = '0;
            n_phase     = ira_pkg::PH_TX_LOW;
        end
    end

    always_comb begin
        o_result.lines      = ira_pkg::lines_for_phase(n_phase, n_tx_shift[7]);
        o_result.busy       = (n_phase != ira_pkg::PH_IDLE);
        o_result.done       = n_done;
        o_result.ack_error  = n_error;
        o_result.read_value = n_rx_shift;
    end

endmodule
`default_nettype wire

@@ src/i2c_register_access_master.sv @@
// Top level: request handshake, result register and configuration port.
`default_nettype none
// One request is one bit-timing tick of the bus and yields exactly one result with the
// SCL/SDA levels to drive for the following tick, plus status and the byte read so far.
// Requests are taken every clock cycle: the sequencer state advances at the edge that
// accepts a request and the result sits in a one-deep output register, so throughput is
// one request per cycle; a request waits only while the output register is full and not
// being taken. ack_timeout_ticks at address 0 bounds how many high SDA samples one
// acknowledge may see before the transaction is aborted with STOP.
module i2c_register_access_master #(
    parameter logic [7:0] TIMEOUT_RESET = ira_pkg::TIMEOUT_RESET
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [6:0]                  i_device_address,
    input  wire logic [7:0]                  i_register_address,
    input  wire logic [7:0]                  i_write_value,
    input  wire logic                        i_sda_sample,
    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      logic                        o_scl_level,
    output      logic                        o_sda_level,
    output      logic                        o_sda_drive,
    output      logic                        o_busy_res,
    output      logic                        o_done_res,
    output      logic                        o_ack_error,
    output      logic [7:0]                  o_read_value,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ira_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ira_pkg::PDATA_W-1:0] pwdata,
    output      logic [ira_pkg::PDATA_W-1:0] prdata,
    output      logic                        pready
);

    logic             r_out_valid;
    ira_pkg::t_result r_out;
    ira_pkg::t_result core_result;
    logic [7:0]       r_ack_timeout;
    logic             accept;
    logic             cfg_sel;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign cfg_sel    = (paddr == ira_pkg::ADDR_ACK_TIMEOUT);
    assign pready     = 1'b1;
    assign prdata     = cfg_sel ? {{(ira_pkg::PDATA_W-8){1'b0}}, r_ack_timeout} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_ack_timeout <= pwdata[7:0];
        end
    end

    ira_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_advance           (accept),
        .i_cmd               (i_cmd),
        .i_device_address    (i_device_address),
        .i_register_address  (i_register_address),
        .i_write_value       (i_write_value),
        .i_sda_sample        (i_sda_sample),
        .i_ack_timeout_ticks (r_ack_timeout),
        .o_result            (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_scl_level  = r_out.lines.scl;
    assign o_sda_level  = r_out.lines.sda;
    assign o_sda_drive  = r_out.lines.drive;
    assign o_busy_res   = r_out.busy;
    assign o_done_res   = r_out.done;
    assign o_ack_error  = r_out.ack_error;
    assign o_read_value = r_out.read_value;

endmodule
`default_nettype wire

@@ tb/i2c_tick_checker.sv @@
// Checker for the I2C register access master: predicts each tick's bus levels and status.
`timescale 1ns / 100ps
module i2c_tick_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [6:0]                  i_device_address,
    input  wire logic [7:0]                  i_register_address,
    input  wire logic [7:0]                  i_write_value,
    input  wire logic                        i_sda_sample,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic                        i_scl_level,
    input  wire logic                        i_sda_level,
    input  wire logic                        i_sda_drive,
    input  wire logic                        i_busy_res,
    input  wire logic                        i_done_res,
    input  wire logic                        i_ack_error,
    input  wire logic [7:0]                  i_read_value,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [ira_pkg::PADDR_W-1:0] i_paddr,
    input  wire logic [ira_pkg::PDATA_W-1:0] i_pwdata,
    input  wire logic                        i_pready,
    output      int                          o_pending,
    output      int                          o_fail_count
);

    logic [7:0]       timeout_cfg;
    ira_pkg::t_phase  seq_phase;
    ira_pkg::t_step   seq_step;
    logic [3:0]       bit_cnt;
    logic [7:0]       tx_byte;
    logic [7:0]       rx_byte;
    logic [7:0]       ack_waits;
    logic [6:0]       dev_l;
    logic [7:0]       reg_l;
    logic [7:0]       val_l;
    logic             rd_mode;
    logic             err;
    ira_pkg::t_result expected_ticks[$];
    int               errors = 0;

    task automatic clear_sequencer();
        timeout_cfg = ira_pkg::TIMEOUT_RESET;
        seq_phase = ira_pkg::PH_IDLE;
        seq_step = ira_pkg::STEP_ADDR;
        bit_cnt = 4'd0;
        tx_byte = 8'd0;
        rx_byte = 8'd0;
        ack_waits = 8'd0;
        dev_l = 7'd0;
        reg_l = 8'd0;
        val_l = 8'd0;
        rd_mode = 1'b0;
        err = 1'b0;
    endtask

    task automatic load_byte();
        case (seq_step)
            ira_pkg::STEP_ADDR: tx_byte = {dev_l, 1'b0};
            ira_pkg::STEP_REG:  tx_byte = reg_l;
            default:            tx_byte = rd_mode ? {dev_l, 1'b1} : val_l;
        endcase
        bit_cnt = 4'd0;
        seq_phase = ira_pkg::PH_TX_LOW;
    endtask

    task automatic step_sequencer(
        input  ira_pkg::t_cmd    cmd,
        input  logic [6:0]       dev,
        input  logic [7:0]       reg_a,
        input  logic [7:0]       val,
        input  logic             sda,
        output ira_pkg::t_result r
    );
        logic            finished;
        ira_pkg::t_lines l;
        finished = 1'b0;
        case (seq_phase)
            ira_pkg::PH_IDLE: begin
                if (cmd == ira_pkg::CMD_WRITE || cmd == ira_pkg::CMD_READ) begin
                    dev_l = dev;
                    reg_l = reg_a;
                    val_l = val;
                    rd_mode = (cmd == ira_pkg::CMD_READ);
                    if (rd_mode) rx_byte = 8'd0;
                    err = 1'b0;
                    seq_step = ira_pkg::STEP_ADDR;
                    bit_cnt = 4'd0;
                    ack_waits = 8'd0;
                    seq_phase = ira_pkg::PH_S1;
                end
            end
            ira_pkg::PH_S1: seq_phase = ira_pkg::PH_S2;
            ira_pkg::PH_S2: seq_phase = ira_pkg::PH_S3;
            ira_pkg::PH_S3: seq_phase = ira_pkg::PH_S4;
            ira_pkg::PH_S4: load_byte();
            ira_pkg::PH_TX_LOW: seq_phase = ira_pkg::PH_TX_HIGH;
            ira_pkg::PH_TX_HIGH: begin
                tx_byte = tx_byte << 1;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    ack_waits = 8'd0;
                    seq_phase = ira_pkg::PH_ACK_LOW;
                end else begin
                    seq_phase = ira_pkg::PH_TX_LOW;
                end
            end
            ira_pkg::PH_ACK_LOW: seq_phase = ira_pkg::PH_ACK_WAIT;
            ira_pkg::PH_ACK_WAIT: begin
                if (!sda) begin
                    case (seq_step)
                        ira_pkg::STEP_ADDR: begin
                            seq_step = ira_pkg::STEP_REG;
                            load_byte();
                        end
                        ira_pkg::STEP_REG: begin
                            seq_step = ira_pkg::STEP_DATA;
                            if (rd_mode) seq_phase = ira_pkg::PH_S1;
                            else load_byte();
                        end
                        default: begin
                            if (rd_mode) begin
                                bit_cnt = 4'd0;
                                seq_phase = ira_pkg::PH_RX_LOW;
                            end else begin
                                seq_phase = ira_pkg::PH_P1;
                            end
                        end
                    endcase
                end else if (ack_waits >= timeout_cfg) begin
                    err = 1'b1;
                    seq_phase = ira_pkg::PH_P1;
                end else begin
                    ack_waits = ack_waits + 8'd1;
                end
            end
            ira_pkg::PH_RX_LOW: seq_phase = ira_pkg::PH_RX_HIGH;
            ira_pkg::PH_RX_HIGH: begin
                rx_byte = {rx_byte[6:0], sda};
                bit_cnt = bit_cnt + 4'd1;
                seq_phase = (bit_cnt >= 4'd8) ? ira_pkg::PH_NACK_LOW : ira_pkg::PH_RX_LOW;
            end
            ira_pkg::PH_NACK_LOW: seq_phase = ira_pkg::PH_NACK_HIGH;
            ira_pkg::PH_NACK_HIGH: seq_phase = ira_pkg::PH_P1;
            ira_pkg::PH_P1: seq_phase = ira_pkg::PH_P2;
            ira_pkg::PH_P2: seq_phase = ira_pkg::PH_P3;
            default: begin
                seq_phase = ira_pkg::PH_IDLE;
                finished = 1'b1;
            end
        endcase
        case (seq_phase)
            ira_pkg::PH_S1:        l = 3'b011;
            ira_pkg::PH_S2:        l = 3'b111;
            ira_pkg::PH_S3:        l = 3'b101;
            ira_pkg::PH_S4:        l = 3'b001;
            ira_pkg::PH_TX_LOW:    l = {1'b0, tx_byte[7], 1'b1};
            ira_pkg::PH_TX_HIGH:   l = {1'b1, tx_byte[7], 1'b1};
            ira_pkg::PH_ACK_LOW:   l = 3'b010;
            ira_pkg::PH_ACK_WAIT:  l = 3'b110;
            ira_pkg::PH_RX_LOW:    l = 3'b010;
            ira_pkg::PH_RX_HIGH:   l = 3'b110;
            ira_pkg::PH_NACK_LOW:  l = 3'b011;
            ira_pkg::PH_NACK_HIGH: l = 3'b111;
            ira_pkg::PH_P1:        l = 3'b001;
            ira_pkg::PH_P2:        l = 3'b101;
            default:               l = 3'b111;
        endcase
        r.lines = l;
        r.busy = (seq_phase != ira_pkg::PH_IDLE);
        r.done = finished;
        r.ack_error = err;
        r.read_value = rx_byte;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        ira_pkg::t_result want;
        ira_pkg::t_result next;
        if (!i_rst_n) begin
            clear_sequencer();
            expected_ticks.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("scl_level", 8'(want.lines.scl), 8'(i_scl_level));
                    check_field("sda_level", 8'(want.lines.sda), 8'(i_sda_level));
                    check_field("sda_drive", 8'(want.lines.drive), 8'(i_sda_drive));
                    check_field("busy_res", 8'(want.busy), 8'(i_busy_res));
                    check_field("done_res", 8'(want.done), 8'(i_done_res));
                    check_field("ack_error", 8'(want.ack_error), 8'(i_ack_error));
                    check_field("read_value", want.read_value, i_read_value);
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_sequencer(ira_pkg::t_cmd'(i_cmd), i_device_address, i_register_address,
                               i_write_value, i_sda_sample, next);
                expected_ticks.push_back(next);
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == ira_pkg::ADDR_ACK_TIMEOUT)
                timeout_cfg = i_pwdata[7:0];
        end
        o_pending <= expected_ticks.size();
        o_fail_count <= errors;
    end

endmodule

@@ tb/tb_i2c_register_access_master.sv @@
// Testbench top for the I2C register access master: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb_i2c_register_access_master;

    typedef enum int {SDA_ACKED, SDA_MIXED, SDA_STUCK} t_sda_mode;

    localparam int LIMIT = 400000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        o_in_ready;
    logic [1:0]                  cmd = ira_pkg::CMD_TICK;
    logic [6:0]                  device_address = 7'd0;
    logic [7:0]                  register_address = 8'd0;
    logic [7:0]                  write_value = 8'd0;
    logic                        sda_sample = 1'b1;
    logic                        o_out_valid;
    logic                        out_ready = 1'b0;
    logic                        o_scl_level;
    logic                        o_sda_level;
    logic                        o_sda_drive;
    logic                        o_busy_res;
    logic                        o_done_res;
    logic                        o_ack_error;
    logic [7:0]                  o_read_value;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ira_pkg::PADDR_W-1:0] paddr = '0;
    logic [ira_pkg::PDATA_W-1:0] pwdata = '0;
    logic [ira_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    int                          pending;
    int                          fail_count;
    int                          cycles = 0;
    int                          results_seen = 0;
    int                          hold_left = 0;
    logic                        long_hold_done = 1'b0;
    logic                        last_busy = 1'b0;
    logic                        quiet = 1'b0;

    always #4 i_clk = ~i_clk;

    i2c_register_access_master dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (cmd),
        .i_device_address   (device_address),
        .i_register_address (register_address),
        .i_write_value      (write_value),
        .i_sda_sample       (sda_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_scl_level        (o_scl_level),
        .o_sda_level        (o_sda_level),
        .o_sda_drive        (o_sda_drive),
        .o_busy_res         (o_busy_res),
        .o_done_res         (o_done_res),
        .o_ack_error        (o_ack_error),
        .o_read_value       (o_read_value),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    i2c_tick_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (o_in_ready),
        .i_cmd              (cmd),
        .i_device_address   (device_address),
        .i_register_address (register_address),
        .i_write_value      (write_value),
        .i_sda_sample       (sda_sample),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .i_scl_level        (o_scl_level),
        .i_sda_level        (o_sda_level),
        .i_sda_drive        (o_sda_drive),
        .i_busy_res         (o_busy_res),
        .i_done_res         (o_done_res),
        .i_ack_error        (o_ack_error),
        .i_read_value       (o_read_value),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_pready           (pready),
        .o_pending          (pending),
        .o_fail_count       (fail_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            last_busy <= o_busy_res;
        end
    end

    // hold off the result side: short bursts, plus one long stall to back up requests
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= 300) begin
            long_hold_done <= 1'b1;
            hold_left <= 63;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_tick(
        input ira_pkg::t_cmd c,
        input logic [6:0]    d,
        input logic [7:0]    ra,
        input logic [7:0]    wv,
        input logic          s
    );
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        device_address <= d;
        register_address <= ra;
        write_value <= wv;
        sda_sample <= s;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // advance with acknowledged ticks until the sequencer is back at idle
    task automatic settle();
        do begin
            send_tick(ira_pkg::CMD_TICK, 7'h00, 8'h00, 8'h00, 1'b0);
            @(negedge i_clk);
            in_valid <= 1'b0;
            wait_drained();
        end while (last_busy);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [7:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ira_pkg::ADDR_ACK_TIMEOUT;
        pwdata <= {24'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic pick_sda(input t_sda_mode m);
        case (m)
            SDA_ACKED: return $urandom_range(0, 7) == 0;
            SDA_MIXED: return 1'($urandom_range(0, 1));
            default:   return 1'b1;
        endcase
    endfunction

    task automatic run_phase(input logic [7:0] timeout, input int count, input t_sda_mode mode);
        int            k;
        ira_pkg::t_cmd c;
        settle();
        write_timeout(timeout);
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 9);
            c = k < 4 ? ira_pkg::CMD_WRITE : k < 8 ? ira_pkg::CMD_READ :
                k == 8 ? ira_pkg::CMD_TICK : ira_pkg::CMD_NONE;
            send_tick(c, 7'($urandom), 8'($urandom), 8'($urandom), pick_sda(mode));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(ira_pkg::CMD_NONE, 7'h7f, 8'hff, 8'hff, 1'b1);
        send_tick(ira_pkg::CMD_TICK, 7'h00, 8'h00, 8'h00, 1'b0);
        send_tick(ira_pkg::CMD_WRITE, 7'h7f, 8'hff, 8'hff, 1'b1);
        send_tick(ira_pkg::CMD_READ, 7'h00, 8'h00, 8'h00, 1'b0);
        repeat (16) send_tick(ira_pkg::CMD_TICK, 7'h55, 8'haa, 8'h0f, 1'b0);

        run_phase(8'd0, 150, SDA_MIXED);
        run_phase(8'd1, 200, SDA_MIXED);
        run_phase(8'd255, 400, SDA_STUCK);
        run_phase(8'd255, 150, SDA_MIXED);
        run_phase(8'($urandom_range(2, 20)), 250, SDA_MIXED);
        quiet = 1'b1;
        run_phase(ira_pkg::TIMEOUT_RESET, 300, SDA_ACKED);

        @(negedge i_clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/ira_pkg.sv
src/ira_core.sv
src/i2c_register_access_master.sv
tb/i2c_tick_checker.sv
tb/tb_i2c_register_access_master.sv
